[rtl/stb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank: command codes,
// the timer record that travels along the cell chain, and field widths.
// ----------------------------------------------------------------------------
package stb_pkg;

   localparam int TIMER_COUNT_DEF = 8;

   localparam int CMD_W    = 3;
   localparam int ID_W     = 8;
   localparam int PERIOD_W = 32;
   localparam int RUN_W    = 31;
   localparam int DIV_W    = 4;

   localparam int REQ_DATA_W = 48;  // 43 bits of fields, padded to bytes
   localparam int RSP_DATA_W = 64;

   localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_START_ONE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_START_PER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CHECK     = 3'd4;

   // running counters return to zero on the tick after reaching this value
   localparam logic [RUN_W-1:0] RUN_LAST   = 31'h7FFF_FFFE;
   localparam logic [DIV_W-1:0] DIV_LAST   = 4'd9;

   typedef struct packed {
      logic [PERIOD_W-1:0] count;
      logic [PERIOD_W-1:0] reload;
      logic                flag;
      logic                periodic;
   } timer_rec_type;

endpackage

[rtl/stb_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_cell
// One timer record in the rotating chain. Takes its neighbor's record when
// the chain advances and holds otherwise.
// ----------------------------------------------------------------------------
module stb_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift,
   input  stb_pkg::timer_rec_type rec_next,
   output stb_pkg::timer_rec_type rec
);
   import stb_pkg::*;

   timer_rec_type rec_ff;
   timer_rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (shift) begin
         rec_in = rec_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule

[rtl/stb_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stb_update
// Head-of-chain update: applies the current request to the record passing
// the head. A tick touches every record; start, stop and check only the one
// whose slot matches the addressed id.
// ----------------------------------------------------------------------------
module stb_update (
   input  logic [stb_pkg::CMD_W-1:0]    cmd,
   input  logic                         hit,
   input  logic [stb_pkg::PERIOD_W-1:0] period,
   input  stb_pkg::timer_rec_type       rec_cur,
   output stb_pkg::timer_rec_type       rec_new,
   output logic                         expired
);
   import stb_pkg::*;

   logic [PERIOD_W-1:0] dec;

   assign dec = rec_cur.count - PERIOD_W'(1);

   always_comb begin
      rec_new = rec_cur;
      expired = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (rec_cur.count != '0) begin
               rec_new.count = dec;
               if (dec == '0) begin
                  rec_new.flag = 1'b1;
                  if (rec_cur.periodic) begin
                     rec_new.count = rec_cur.reload;
                  end
               end
            end
         end
         CMD_START_ONE, CMD_START_PER: begin
            if (hit) begin
               rec_new.count    = period;
               rec_new.reload   = period;
               rec_new.flag     = 1'b0;
               rec_new.periodic = (cmd == CMD_START_PER);
            end
         end
         CMD_STOP: begin
            if (hit) begin
               rec_new.count    = '0;
               rec_new.flag     = 1'b0;
               rec_new.periodic = 1'b0;
            end
         end
         CMD_CHECK: begin
            if (hit) begin
               expired      = rec_cur.flag;
               rec_new.flag = 1'b0;
            end
         end
         default: begin
            rec_new = rec_cur;
         end
      endcase
   end

endmodule

[rtl/soft_timer_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_timer_bank
// Bank of countdown timers kept as a rotating chain of cells, with running
// 1 ms and 10 ms counters advanced by tick requests.
//
//   channel | dir | fields (low bit up)
//   req_    | in  | command[2:0], timer_id[10:3], period[42:11]
//   rsp_    | out | expired[0], bad_id[1], run_time_ms[32:2], run_time_10ms[63:33]
//
// A tick, or a start, stop or check with a valid id, rotates the records once
// past the update unit at the chain head, then loads the response and takes
// the next request once back in idle. A bad id or an unused command skips
// the rotation and goes straight to the response load. Reset is synchronous;
// a held response only delays the next load.
// ----------------------------------------------------------------------------
module soft_timer_bank #(
   parameter int TIMER_COUNT = stb_pkg::TIMER_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // command[2:0], timer_id[10:3], period[42:11], zero pad
   input  logic [stb_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // expired[0], bad_id[1], run_time_ms[32:2], run_time_10ms[63:33]
   output logic [stb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import stb_pkg::*;

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic                exp_ff, exp_in;
   logic                bad_ff, bad_in;

   logic [RUN_W-1:0]    ms_ff, ms_in;
   logic [RUN_W-1:0]    ten_ff, ten_in;
   logic [DIV_W-1:0]    div_ff, div_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [CMD_W-1:0]    req_cmd;
   logic [ID_W-1:0]     req_id;
   logic                req_fire;
   logic                id_ok;
   logic                cmd_addr;
   logic                shift;
   logic                hit;
   logic                head_exp;
   logic                rsp_free;

   timer_rec_type chain [TIMER_COUNT];
   timer_rec_type head_new;

   assign req_cmd  = req_tdata[CMD_W-1:0];
   assign req_id   = req_tdata[CMD_W+ID_W-1:CMD_W];
   assign req_fire = req_tvalid && req_tready;
   assign id_ok    = ({1'b0, req_id} < (ID_W + 1)'(TIMER_COUNT));
   assign cmd_addr = req_cmd inside {CMD_START_ONE, CMD_START_PER, CMD_STOP, CMD_CHECK};
   assign shift    = (state_ff == ST_SWEEP);
   assign hit      = (id_ff[IDX_W-1:0] == slot_ff);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);

   // cell chain: each cell takes its upper neighbor, the top cell takes the
   // updated head record
   genvar g;
   generate
      for (g = 0; g < TIMER_COUNT; g++) begin : g_cell
         timer_rec_type nxt;
         if (g == TIMER_COUNT - 1) begin : g_top
            assign nxt = head_new;
         end else begin : g_mid
            assign nxt = chain[g+1];
         end
         stb_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift    (shift),
            .rec_next (nxt),
            .rec      (chain[g])
         );
      end
   endgenerate

   stb_update u_update (
      .cmd     (cmd_ff),
      .hit     (hit),
      .period  (period_ff),
      .rec_cur (chain[0]),
      .rec_new (head_new),
      .expired (head_exp)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      id_in        = id_ff;
      period_in    = period_ff;
      slot_in      = slot_ff;
      exp_in       = exp_ff;
      bad_in       = bad_ff;
      ms_in        = ms_ff;
      ten_in       = ten_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_cmd;
               id_in     = req_id;
               period_in = req_tdata[CMD_W+ID_W+PERIOD_W-1:CMD_W+ID_W];
               slot_in   = '0;
               exp_in    = 1'b0;
               bad_in    = cmd_addr && !id_ok;
               if (req_cmd == CMD_TICK) begin
                  ms_in = (ms_ff == RUN_LAST) ? '0 : ms_ff + RUN_W'(1);
                  if (div_ff == DIV_LAST) begin
                     div_in = '0;
                     ten_in = (ten_ff == RUN_LAST) ? '0 : ten_ff + RUN_W'(1);
                  end else begin
                     div_in = div_ff + DIV_W'(1);
                  end
               end
               if ((req_cmd == CMD_TICK) || (cmd_addr && id_ok)) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            // gather the check result as the addressed record passes
            exp_in  = exp_ff | head_exp;
            slot_in = slot_ff + IDX_W'(1);
            if (slot_ff == IDX_W'(TIMER_COUNT - 1)) begin
               slot_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ten_ff, ms_ff, bad_ff, exp_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         ms_ff        <= '0;
         ten_ff       <= '0;
         div_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         ms_ff        <= ms_in;
         ten_ff       <= ten_in;
         div_ff       <= div_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      id_ff       <= id_in;
      period_ff   <= period_in;
      exp_ff      <= exp_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
